### rtl/rx_fifo_frame_payload_extractor_top_macros.svh
// Assertion macros for the receive frame payload extractor.
`ifndef RX_FIFO_FRAME_PAYLOAD_EXTRACTOR_TOP_MACROS_SVH
`define RX_FIFO_FRAME_PAYLOAD_EXTRACTOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// lbl: assertion label, prop: property checked on every clk_i edge out of reset
`define RXFPE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rxfpe assertion failed");
// cond must never hold
`define RXFPE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rxfpe forbidden condition seen");
`else
`define RXFPE_ASSERT(lbl, prop)
`define RXFPE_ASSERT_NEVER(lbl, cond)
`endif

`endif

### rtl/rxfpe_pkg.sv
// Package: types and constants of the receive frame payload extractor.
package rxfpe_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  // frame-control high byte codes
  localparam logic [ByteW-1:0] FcLong  = 8'hcc;
  localparam logic [ByteW-1:0] FcShort = 8'h88;

  // header lengths and checksum length, in bytes
  localparam logic [IdxW-1:0] HdrShort = 9'd9;
  localparam logic [IdxW-1:0] HdrLong  = 9'd21;
  localparam logic [IdxW:0]   FcsBytes = 10'd2;

  // addressing modes
  localparam logic [ModeW-1:0] ModeShort = 2'd0;
  localparam logic [ModeW-1:0] ModeLong  = 2'd1;
  localparam logic [ModeW-1:0] ModeNone  = 2'd2;

  // result kinds
  localparam logic KindByte    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // register index
  localparam logic RegRawMode = 1'b0;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data;
    logic             is_payload;
    logic             last_payload;
    logic [ModeW-1:0] addressing;
    logic [ByteW-1:0] frame_len;
    logic [ByteW-1:0] link_quality;
    logic [ByteW-1:0] signal_strength;
  } result_t;

  function automatic logic [ModeW-1:0] decode_fc(input logic [ByteW-1:0] fc);
    logic [ModeW-1:0] mode;
    if (fc == FcLong) begin
      mode = ModeLong;
    end else if (fc == FcShort) begin
      mode = ModeShort;
    end else begin
      mode = ModeNone;
    end
    return mode;
  endfunction

endpackage

### rtl/rx_fifo_frame_payload_extractor_top.sv
// Top level: receive buffer frame parser with payload extraction and summary.
// A result is registered in the output register, or in the skid register on a stall.
// Throughput: one input word per cycle unless in_stall_o; one result at most per word.
// A two-entry output (result register plus skid register) keeps input flowing while
// the output is stalled; in_stall_o rises only when the skid is full.
// Reset (rst_ni low, asynchronous): no frame open, mode unknown, raw mode off, output empty.
`include "rx_fifo_frame_payload_extractor_top_macros.svh"

module rx_fifo_frame_payload_extractor_top
  import rxfpe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // APB-style configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // input word channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] byte_value_i,
  input  logic             frame_start_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             out_kind_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic             is_payload_o,
  output logic             last_payload_o,
  output logic [ModeW-1:0] addressing_o,
  output logic [ByteW-1:0] frame_len_o,
  output logic [ByteW-1:0] link_quality_o,
  output logic [ByteW-1:0] signal_strength_o
);

  // ---------------------------------------------------------------------------
  // Configuration register. Register index is byte address / 4.
  // ---------------------------------------------------------------------------
  logic raw_mode_q;
  logic cfg_wr;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[AddrW-1] == RegRawMode);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {{(DataW-1){1'b0}}, raw_mode_q && cfg_hit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q <= 1'b0;
    end else if (cfg_wr && cfg_hit) begin
      raw_mode_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Frame tracking state
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0]  byte_idx_q, byte_idx_d;
  logic [ByteW-1:0] length_q, length_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [ByteW-1:0] quality_q, quality_d;
  logic             in_frame_q, in_frame_d;

  logic             skid_valid_q;
  logic             out_valid_q;
  logic             in_acc;

  // Input is taken unless the skid already holds a pending result.
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;

  // Per-word decode. Position is the count of frame words since the length word;
  // positions below length are frame bytes, position == length is link quality,
  // the word after that is signal strength and closes the frame.
  logic [IdxW:0]    len_ext;
  logic [IdxW:0]    pos_ext;
  logic             pos_in_body;
  logic             pos_is_lqi;
  logic [ModeW-1:0] mode_cur;
  logic [IdxW-1:0]  hdr_len;
  logic             pay;
  logic             last;
  logic             res_valid;
  result_t          res;

  always_comb begin
    len_ext     = {2'b00, length_q};
    pos_ext     = {1'b0, byte_idx_q};
    pos_in_body = (pos_ext < len_ext);
    pos_is_lqi  = (pos_ext == len_ext);

    // the second frame byte picks the addressing mode, visible on that same byte
    mode_cur = (byte_idx_q == IdxW'(1)) ? decode_fc(byte_value_i) : mode_q;
    hdr_len  = (mode_cur == ModeLong) ? HdrLong : HdrShort;

    // header is always at least 9 bytes, so the frame-control bytes never qualify
    pay  = (mode_cur != ModeNone) && (byte_idx_q >= hdr_len) &&
           (pos_ext + FcsBytes < len_ext);
    last = pay && (pos_ext + FcsBytes + (IdxW+1)'(1) == len_ext);

    res_valid = 1'b0;
    res       = '0;

    byte_idx_d = byte_idx_q;
    length_d   = length_q;
    mode_d     = mode_q;
    quality_d  = quality_q;
    in_frame_d = in_frame_q;

    if (in_acc) begin
      if (frame_start_i) begin
        // a start always opens a fresh frame; any frame in progress is dropped
        length_d   = byte_value_i;
        byte_idx_d = '0;
        mode_d     = ModeNone;
        quality_d  = '0;
        in_frame_d = 1'b1;
      end else if (in_frame_q) begin
        byte_idx_d = byte_idx_q + IdxW'(1);
        if (pos_in_body) begin
          mode_d = mode_cur;
          if (pay || raw_mode_q) begin
            res_valid        = 1'b1;
            res.kind         = KindByte;
            res.data         = byte_value_i;
            res.is_payload   = pay;
            res.last_payload = last;
            res.addressing   = mode_cur;
            res.frame_len    = length_q;
          end
        end else if (pos_is_lqi) begin
          quality_d = byte_value_i;
        end else begin
          // strength word: emit summary, go idle
          in_frame_d          = 1'b0;
          byte_idx_d          = '0;
          res_valid           = 1'b1;
          res.kind            = KindSummary;
          res.addressing      = mode_q;
          res.frame_len       = length_q;
          res.link_quality    = quality_q;
          res.signal_strength = byte_value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= '0;
      length_q   <= '0;
      mode_q     <= ModeNone;
      quality_q  <= '0;
      in_frame_q <= 1'b0;
    end else begin
      byte_idx_q <= byte_idx_d;
      length_q   <= length_d;
      mode_q     <= mode_d;
      quality_q  <= quality_d;
      in_frame_q <= in_frame_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid
  // ---------------------------------------------------------------------------
  result_t out_q;
  result_t skid_q;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_q.kind;
  assign out_byte_o        = out_q.data;
  assign is_payload_o      = out_q.is_payload;
  assign last_payload_o    = out_q.last_payload;
  assign addressing_o      = out_q.addressing;
  assign frame_len_o       = out_q.frame_len;
  assign link_quality_o    = out_q.link_quality;
  assign signal_strength_o = out_q.signal_strength;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RXFPE_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q)
  `RXFPE_ASSERT(a_idx_in_range, in_frame_q |-> (pos_ext <= len_ext + (IdxW+1)'(1)))
  `RXFPE_ASSERT(a_payload_has_mode,
                (out_valid_q && out_kind_o == KindByte && is_payload_o) |-> (addressing_o != ModeNone))
  `RXFPE_ASSERT_NEVER(a_last_without_payload, out_valid_q && last_payload_o && !is_payload_o)
  `RXFPE_ASSERT(a_summary_clean,
                (out_valid_q && out_kind_o == KindSummary) |-> (!is_payload_o && out_byte_o == '0))

endmodule
